>>> rtl/sbvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbvc_pkg
// Shared types and constants for the swept-box voxel collision block.
// ----------------------------------------------------------------------------
package sbvc_pkg;

    localparam int GRID_SIZE = 32;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W = 24;
    localparam int TOL_W   = 16;
    localparam int WIDE_W  = 28;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MOVE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_NEXT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

>>> rtl/sbvc_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbvc_map
// Voxel map memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sbvc_map #(
    parameter int ADDR_W = 15
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic              wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic                   rdata
);
    logic mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/swept_box_voxel_collision_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swept_box_voxel_collision_top
// Resolves a box move axis by axis against a solid/empty voxel map, and writes map cells.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_axis  | in  | tdata: op, cell_index, solid, box min xyz, box max xyz, move xyz
//  m_axis  | out | tdata: allowed_x, allowed_y, allowed_z
//  cfg     | in  | cfg_we/cfg_wdata: cell widening tolerance
// A write transaction goes from the accepting idle state straight to the done state.
// A move passes from the accepting state through, per axis, the setup state,
// the scan state for the visited cells (entered even if the range is empty),
// the drain state and the update state, then the done state; the single map read port sets the scan pace.
// After reset a clearing pass writes every map cell empty while s_tready stays
// low. A finished result waits in the done state only while the previous result
// still sits untaken in the output register.
module swept_box_voxel_collision_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // fields from bit 0: op, cell_index, solid,
    // box_min_x,y,z, box_max_x,y,z, move_x,y,z; zero fill to 240 bits
    input  wire logic [239:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // allowed_x, allowed_y, allowed_z from bit 0
    output logic [71:0]       m_tdata
);
    import sbvc_pkg::*;

    localparam int G_W    = $clog2(GRID_SIZE);
    localparam int ADDR_W = 3 * G_W;
    localparam int CNT_W  = G_W + 1;
    localparam int CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) <<< FRAC_BITS;

    state_t state_reg, state_next;
    logic [TOL_W-1:0] tol_reg;
    logic [ADDR_W:0] clr_reg;
    logic [1:0] ax_reg;
    logic signed [WIDE_W-1:0] bmin_reg [3];
    logic signed [WIDE_W-1:0] bmax_reg [3];
    logic signed [WIDE_W-1:0] mv_reg [3];
    logic signed [WIDE_W-1:0] res_reg [3];
    logic signed [WIDE_W-1:0] adj_reg;
    logic [CNT_W-1:0] st_reg [3];
    logic [CNT_W-1:0] en_reg [3];
    logic [CNT_W-1:0] c_reg [3];
    logic [CNT_W-1:0] pc_reg [3];
    logic pv_reg;
    logic [71:0] out_reg;
    logic vld_reg;

    // map port
    logic map_we, map_wd, map_rd;
    logic [ADDR_W-1:0] map_wa, map_ra;

    sbvc_map #(.ADDR_W(ADDR_W)) u_map (
        .aclk(aclk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
        .raddr(map_ra), .rdata(map_rd)
    );

    logic op;
    logic [14:0] cidx;
    assign op   = s_tdata[0];
    assign cidx = s_tdata[15:1];
    logic acc;
    assign acc = s_tvalid && s_tready;

    // load the output register once the previous result is gone
    logic load_out;
    assign load_out = (state_reg == ST_DONE) && (!vld_reg || m_tready);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = vld_reg;
    assign m_tdata  = out_reg;

    function automatic logic signed [WIDE_W-1:0] flr(input logic signed [WIDE_W-1:0] v);
        flr = v >>> FRAC_BITS;
    endfunction

    // scan address, last-cell detection
    logic last_cell;
    assign last_cell = (c_reg[2] + 1'b1 >= en_reg[2]) && (c_reg[1] + 1'b1 >= en_reg[1])
                     && (c_reg[0] + 1'b1 >= en_reg[0]);
    logic empty_rng;
    assign empty_rng = (st_reg[0] >= en_reg[0]) || (st_reg[1] >= en_reg[1])
                     || (st_reg[2] >= en_reg[2]);

    always_comb begin
        map_ra = '0;
        for (int i = 0; i < 3; i++) begin
            map_ra[(2-i)*G_W +: G_W] = c_reg[i][G_W-1:0];
        end
        map_we = 1'b0;
        map_wa = cidx[ADDR_W-1:0];
        map_wd = s_tdata[16];
        if (state_reg == ST_CLEAR) begin
            map_we = 1'b1;
            map_wa = clr_reg[ADDR_W-1:0];
            map_wd = 1'b0;
        end else if (acc && op == OP_WRITE && 32'(cidx) < CELLS) begin
            map_we = 1'b1;
        end
    end

    // hit test on the previously read cell
    logic signed [WIDE_W-1:0] mmin [3], mmax [3], cl [3], ch [3];
    logic hit;
    logic signed [WIDE_W-1:0] adj_upd;
    always_comb begin
        hit = pv_reg && map_rd;
        for (int i = 0; i < 3; i++) begin
            mmin[i] = bmin_reg[i] + ((2'(i) == ax_reg) ? mv_reg[i] : '0);
            mmax[i] = bmax_reg[i] + ((2'(i) == ax_reg) ? mv_reg[i] : '0);
            cl[i] = WIDE_W'($signed({1'b0, pc_reg[i]})) <<< FRAC_BITS;
            ch[i] = cl[i] + ONE;
            if (2'(i) == ax_reg) begin
                cl[i] = cl[i] - WIDE_W'($signed({1'b0, tol_reg}));
                ch[i] = ch[i] + WIDE_W'($signed({1'b0, tol_reg}));
            end
            if (!(mmin[i] < ch[i] && mmax[i] > cl[i])) hit = 1'b0;
        end
        adj_upd = adj_reg;
        if (hit) begin
            if (adj_reg > 0) begin
                if (cl[ax_reg] - bmax_reg[ax_reg] < adj_upd)
                    adj_upd = cl[ax_reg] - bmax_reg[ax_reg];
                if (adj_upd < 0) adj_upd = '0;
            end else begin
                if (ch[ax_reg] - bmin_reg[ax_reg] > adj_upd)
                    adj_upd = ch[ax_reg] - bmin_reg[ax_reg];
                if (adj_upd > 0) adj_upd = '0;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (acc) state_next = (op == OP_WRITE) ? ST_DONE : ST_SETUP;
            ST_CLEAR: if (clr_reg == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
            ST_SETUP: state_next = ST_SCAN;
            ST_SCAN:  if (empty_rng || last_cell) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_NEXT;
            ST_NEXT:  state_next = (ax_reg == 2'd2) ? ST_DONE : ST_SETUP;
            ST_DONE:  if (!vld_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            tol_reg   <= 16'd7;
            clr_reg   <= '0;
            vld_reg   <= 1'b0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) tol_reg <= cfg_wdata;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            pv_reg <= (state_reg == ST_SCAN) && !empty_rng;
            if (load_out) begin
                out_reg <= {res_reg[2][COORD_W-1:0], res_reg[1][COORD_W-1:0],
                            res_reg[0][COORD_W-1:0]};
                vld_reg <= 1'b1;
            end else if (m_tready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    // datapath
    logic signed [WIDE_W-1:0] lo, hi, fl, fh;
    always_comb begin
        lo = '0; hi = '0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) == ax_reg) begin
                lo = (mmin[i] < bmin_reg[i]) ? mmin[i] : bmin_reg[i];
                hi = (mmax[i] > bmax_reg[i]) ? mmax[i] : bmax_reg[i];
            end
        end
        fl = flr(lo);
        fh = flr(hi) + WIDE_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            if (op == OP_MOVE) begin
                for (int i = 0; i < 3; i++) begin
                    bmin_reg[i] <= WIDE_W'($signed(s_tdata[17 + 24*i +: 24]));
                    bmax_reg[i] <= WIDE_W'($signed(s_tdata[89 + 24*i +: 24]));
                    mv_reg[i]   <= WIDE_W'($signed(s_tdata[161 + 24*i +: 24]));
                end
                ax_reg <= 2'd0;
            end else begin
                for (int i = 0; i < 3; i++) res_reg[i] <= '0;
            end
        end
        unique case (state_reg)
            ST_SETUP: begin
                adj_reg <= mv_reg[ax_reg];
                for (int i = 0; i < 3; i++) begin
                    logic signed [WIDE_W-1:0] a, b;
                    a = flr(bmin_reg[i]);
                    b = flr(bmax_reg[i]) + WIDE_W'(1);
                    if (2'(i) == ax_reg) begin a = fl; b = fh; end
                    st_reg[i] <= (a < 0) ? '0 : (a > GRID_SIZE) ? CNT_W'(GRID_SIZE)
                                : a[CNT_W-1:0];
                    en_reg[i] <= (b > GRID_SIZE) ? CNT_W'(GRID_SIZE)
                                : (b < 0) ? '0 : b[CNT_W-1:0];
                    c_reg[i] <= (a < 0) ? '0 : (a > GRID_SIZE) ? CNT_W'(GRID_SIZE)
                                : a[CNT_W-1:0];
                end
            end
            ST_SCAN: begin
                adj_reg <= adj_upd;
                for (int i = 0; i < 3; i++) pc_reg[i] <= c_reg[i];
                if (c_reg[2] + 1'b1 < en_reg[2]) c_reg[2] <= c_reg[2] + 1'b1;
                else begin
                    c_reg[2] <= st_reg[2];
                    if (c_reg[1] + 1'b1 < en_reg[1]) c_reg[1] <= c_reg[1] + 1'b1;
                    else begin
                        c_reg[1] <= st_reg[1];
                        c_reg[0] <= c_reg[0] + 1'b1;
                    end
                end
            end
            ST_DRAIN: adj_reg <= adj_upd;
            ST_NEXT: begin
                res_reg[ax_reg]  <= adj_reg;
                bmin_reg[ax_reg] <= bmin_reg[ax_reg] + adj_reg;
                bmax_reg[ax_reg] <= bmax_reg[ax_reg] + adj_reg;
                if (ax_reg != 2'd2) ax_reg <= ax_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg && !m_tready |=> vld_reg && $stable(out_reg))
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("input taken during clear");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> ax_reg != 2'd3)
        else $error("bad axis");
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept-box voxel collision testbench
// Drives map writes and box moves into swept_box_voxel_collision_top, predicts
// each resolved displacement from a local copy of the voxel map and the sweep
// tolerance, and checks every result transaction in order. Both sides idle at
// random; tolerance settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import sbvc_pkg::*;

    localparam int  GRID      = 32;
    localparam int  FRAC      = 16;
    localparam longint ONE_FX = longint'(1) << FRAC;
    localparam int  WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic               op;
        logic [14:0]        cell_idx;
        logic               solid;
        logic signed [23:0] bmin [3];
        logic signed [23:0] bmax [3];
        logic signed [23:0] mv   [3];
    } voxel_req_t;

    typedef struct {
        logic signed [23:0] allowed [3];
    } displacement_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [239:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    swept_box_voxel_collision_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // op, cell_index, solid, box_min xyz, box_max xyz, move xyz
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // allowed_x, allowed_y, allowed_z
    );

    always #5 aclk = ~aclk;

    // Local copy of the block's state.
    bit          voxel_map [GRID*GRID*GRID];
    logic [15:0] tolerance_q = 16'd7;

    voxel_req_t    pending_reqs [$];
    displacement_t expected_moves [$];
    voxel_req_t    cur_req;

    int  error_count = 0;
    int  result_count = 0;
    int  req_count = 0;
    int  move_count = 0;
    bit  idle_enable = 1'b1;
    bit  long_hold_req = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  recv_hold = 0;
    int  quiet_cycles = 0;
    logic next_valid;

    function automatic logic [239:0] pack_req(voxel_req_t r);
        logic [239:0] d;
        d = '0;
        d[0]     = r.op;
        d[15:1]  = r.cell_idx;
        d[16]    = r.solid;
        for (int i = 0; i < 3; i++) begin
            d[17  + 24*i +: 24] = r.bmin[i];
            d[89  + 24*i +: 24] = r.bmax[i];
            d[161 + 24*i +: 24] = r.mv[i];
        end
        return d;
    endfunction

    // Resolve one axis of the move against the local map.
    function automatic longint sweep_axis(longint bmin[3], longint bmax[3],
                                          longint mv[3], int ax);
        longint mmin[3], mmax[3], first[3], last[3], cl[3], ch[3];
        longint delta, lo, hi, nd;
        bit hit;
        delta = mv[ax];
        for (int i = 0; i < 3; i++) begin
            mmin[i] = bmin[i] + ((i == ax) ? mv[ax] : 0);
            mmax[i] = bmax[i] + ((i == ax) ? mv[ax] : 0);
            lo = (mmin[i] < bmin[i]) ? mmin[i] : bmin[i];
            hi = (mmax[i] > bmax[i]) ? mmax[i] : bmax[i];
            first[i] = lo >>> FRAC;
            if (first[i] < 0) first[i] = 0;
            last[i] = (hi >>> FRAC) + 1;
            if (last[i] > GRID) last[i] = GRID;
        end
        for (longint x = first[0]; x < last[0]; x++)
            for (longint y = first[1]; y < last[1]; y++)
                for (longint z = first[2]; z < last[2]; z++) begin
                    if (!voxel_map[(x*GRID + y)*GRID + z]) continue;
                    cl[0] = x * ONE_FX; cl[1] = y * ONE_FX; cl[2] = z * ONE_FX;
                    hit = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        ch[i] = cl[i] + ONE_FX;
                        if (i == ax) begin
                            cl[i] -= tolerance_q;
                            ch[i] += tolerance_q;
                        end
                        if (!(mmin[i] < ch[i] && mmax[i] > cl[i])) hit = 1'b0;
                    end
                    if (!hit) continue;
                    // Clamp toward the near face, never reversing the sign.
                    if (delta > 0) begin
                        nd = cl[ax] - bmax[ax];
                        if (nd < delta) delta = nd;
                        if (delta < 0) delta = 0;
                    end else begin
                        nd = ch[ax] - bmin[ax];
                        if (nd > delta) delta = nd;
                        if (delta > 0) delta = 0;
                    end
                end
        return delta;
    endfunction

    function automatic displacement_t apply_req(voxel_req_t r);
        displacement_t res;
        longint bmin[3], bmax[3], mv[3], d;
        for (int i = 0; i < 3; i++) res.allowed[i] = '0;
        if (r.op == OP_WRITE) begin
            voxel_map[r.cell_idx] = r.solid;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            bmin[i] = r.bmin[i]; bmax[i] = r.bmax[i]; mv[i] = r.mv[i];
        end
        for (int i = 0; i < 3; i++) begin
            d = sweep_axis(bmin, bmax, mv, i);
            res.allowed[i] = d[23:0];
            bmin[i] += d;
            bmax[i] += d;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] result %0d %s: got %0d, expected %0d",
                 $realtime, result_count, what, got, want);
        error_count++;
    endtask

    // Driver: present one pending transaction at a time, predict on acceptance.
    always @(posedge aclk) begin
        next_valid = s_tvalid;
        if (s_tvalid && s_tready) begin
            expected_moves.push_back(apply_req(cur_req));
            req_count++;
            next_valid = 1'b0;
        end
        if (!next_valid && aresetn) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                s_tdata <= pack_req(cur_req);
                next_valid = 1'b1;
                // Open an idle burst after this transaction now and then.
                if (idle_enable && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 14);
            end
        end
        s_tvalid <= next_valid;
    end

    // Monitor: check each result transaction against the oldest prediction.
    always @(posedge aclk) begin
        displacement_t want;
        logic signed [23:0] got;
        if (m_tvalid && m_tready) begin
            if (expected_moves.size() == 0) begin
                got = m_tdata[23:0];
                report_mismatch("unexpected transaction, allowed[0]", got, 0);
            end else begin
                want = expected_moves.pop_front();
                for (int i = 0; i < 3; i++) begin
                    got = m_tdata[24*i +: 24];
                    if (got !== want.allowed[i])
                        report_mismatch($sformatf("allowed[%0d]", i), got, want.allowed[i]);
                end
            end
            result_count++;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req && recv_hold == 0) begin
            long_hold_req = 1'b0;
            recv_hold = 400;
            m_tready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold--;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            if (idle_enable && $urandom_range(0, 9) == 0)
                recv_gap = $urandom_range(1, 14);
            m_tready <= (recv_gap == 0);
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired: %0d results, %0d still expected",
                     result_count, expected_moves.size());
            $display("swept_box_voxel_collision_top: mismatch");
            $finish;
        end
    end

    function automatic voxel_req_t make_write(int x, int y, int z, bit solid);
        voxel_req_t r;
        r = '{op: OP_WRITE, cell_idx: 15'((x*GRID + y)*GRID + z), solid: solid,
              bmin: '{0, 0, 0}, bmax: '{0, 0, 0}, mv: '{0, 0, 0}};
        return r;
    endfunction

    function automatic voxel_req_t make_move(longint lo[3], longint hi[3], longint mv[3]);
        voxel_req_t r;
        r.op = OP_MOVE;
        r.cell_idx = 15'($urandom());
        r.solid = 1'($urandom());
        for (int i = 0; i < 3; i++) begin
            r.bmin[i] = lo[i][23:0];
            r.bmax[i] = hi[i][23:0];
            r.mv[i]   = mv[i][23:0];
        end
        return r;
    endfunction

    // Random transaction: mostly writes and moves around a dense corner of the map.
    function automatic voxel_req_t random_req();
        voxel_req_t r;
        longint lo[3], hi[3], mv[3], ext;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r = make_write($urandom_range(0, 9), $urandom_range(0, 9),
                           $urandom_range(0, 9), $urandom_range(0, 2) != 0);
            r.bmin[0] = 24'($urandom());  // unused fields still toggle
            return r;
        end
        if (pick < 36) begin
            r = make_write(0, 0, 0, 1'($urandom()));
            r.cell_idx = 15'($urandom());
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            ext   = $urandom_range(0, 2*ONE_FX);
            lo[i] = longint'($urandom_range(0, 11*ONE_FX)) - ONE_FX;
            mv[i] = longint'($urandom_range(0, 6*ONE_FX)) - 3*ONE_FX;
            if (pick >= 94) begin
                // Noise: full-width corners and moves, box kept narrow.
                lo[i] = longint'(signed'(24'($urandom())));
                mv[i] = longint'(signed'(24'($urandom())));
                if (lo[i] + ext > 8388607) lo[i] -= ext;
            end
            hi[i] = lo[i] + ext;
            if (pick >= 91 && pick < 94 && i == 0) begin
                // Inverted box.
                hi[i] = lo[i];
                lo[i] = lo[i] + ext + 1;
            end
            if ($urandom_range(0, 5) == 0) mv[i] = 0;
        end
        return make_move(lo, hi, mv);
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_moves.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [15:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tolerance_q = value;
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) pending_reqs.push_back(random_req());
    endtask

    initial begin
        longint lo[3], hi[3], mv[3];
        voxel_req_t r;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a solid cell at (4,4,4) approached from every side.
        pending_reqs.push_back(make_write(4, 4, 4, 1'b1));
        pending_reqs.push_back(make_write(0, 0, 0, 1'b1));
        pending_reqs.push_back(make_write(31, 31, 31, 1'b1));
        for (int ax = 0; ax < 3; ax++) begin
            for (int s = 0; s < 2; s++) begin
                for (int i = 0; i < 3; i++) begin
                    lo[i] = 4*ONE_FX + ONE_FX/4;
                    hi[i] = lo[i] + ONE_FX/2;
                    mv[i] = 0;
                end
                lo[ax] = s ? 6*ONE_FX : 2*ONE_FX;
                hi[ax] = lo[ax] + ONE_FX/2;
                mv[ax] = s ? -3*ONE_FX : 3*ONE_FX;
                pending_reqs.push_back(make_move(lo, hi, mv));
            end
        end
        // Extreme moves from a small box, and a box outside the grid.
        lo = '{ONE_FX, ONE_FX, ONE_FX}; hi = '{ONE_FX+5, ONE_FX+5, ONE_FX+5};
        mv = '{8388607, -8388608, 8388607};
        pending_reqs.push_back(make_move(lo, hi, mv));
        lo = '{-8388608, -8388608, -8388608}; hi = '{-8388000, -8388000, -8388000};
        mv = '{-8388608, 8388607, -8388608};
        pending_reqs.push_back(make_move(lo, hi, mv));
        // Inverted box.
        lo = '{5*ONE_FX, 4*ONE_FX, 4*ONE_FX}; hi = '{3*ONE_FX, 5*ONE_FX, 5*ONE_FX};
        mv = '{ONE_FX, 0, 0};
        pending_reqs.push_back(make_move(lo, hi, mv));
        // Box spanning the whole field range: visits every cell on all axes.
        lo = '{-8388608, -8388608, -8388608}; hi = '{8388607, 8388607, 8388607};
        mv = '{ONE_FX, -ONE_FX, ONE_FX};
        pending_reqs.push_back(make_move(lo, hi, mv));
        // Clear the cell and retry one approach, then the last map entry.
        pending_reqs.push_back(make_write(4, 4, 4, 1'b0));
        lo = '{2*ONE_FX, 4*ONE_FX, 4*ONE_FX}; hi = '{3*ONE_FX, 5*ONE_FX, 5*ONE_FX};
        mv = '{3*ONE_FX, 0, 0};
        pending_reqs.push_back(make_move(lo, hi, mv));
        r = make_write(31, 31, 31, 1'b0);
        r.cell_idx = 15'h7FFF;
        pending_reqs.push_back(r);

        random_phase(300);
        write_tolerance(16'd0);
        // Sender keeps offering while the receiver holds off.
        long_hold_req = 1'b1;
        random_phase(300);
        write_tolerance(16'hFFFF);
        random_phase(250);
        write_tolerance(16'($urandom()));
        random_phase(200);
        write_tolerance(16'd7);
        wait_drained();
        idle_enable = 1'b0;
        random_phase(200);
        wait_drained();
        repeat (50) @(posedge aclk);

        $display("covered %0d transactions (%0d results), tolerance 7, 0, 65535, random",
                 req_count, result_count);
        $display("map writes, moves near solid cells, outside-grid and inverted boxes");
        if (error_count == 0 && expected_moves.size() == 0) begin
            $display("swept_box_voxel_collision_top: match");
        end else begin
            $display("swept_box_voxel_collision_top: mismatch");
        end
        $finish;
    end

endmodule
